>>> design/nbbo_pkg.sv
package nbbo_pkg;

  // Pixel coordinates are 12 bits; edges are 14-bit signed values.
  localparam int CELL_W  = 11;
  localparam int COORD_W = 12;
  localparam int EDGE_W  = 14;
  localparam int CMP_W   = 16;
  localparam int PIX_W   = 8;

  localparam int IDX_W   = 4;
  localparam int CFG_W   = 16;
  localparam int IN_W    = 72;
  localparam int OUT_W   = 48;

  localparam logic [IDX_W-1:0] REG_BOX_LEFT   = 4'd0;
  localparam logic [IDX_W-1:0] REG_BOX_TOP    = 4'd1;
  localparam logic [IDX_W-1:0] REG_BOX_RIGHT  = 4'd2;
  localparam logic [IDX_W-1:0] REG_BOX_BOTTOM = 4'd3;
  localparam logic [IDX_W-1:0] REG_THICKNESS  = 4'd4;
  localparam logic [IDX_W-1:0] REG_PAINT_LUMA = 4'd5;
  localparam logic [IDX_W-1:0] REG_PAINT_CB   = 4'd6;
  localparam logic [IDX_W-1:0] REG_PAINT_CR   = 4'd7;

  localparam logic [EDGE_W-1:0] RST_EDGE       = 14'd0;
  localparam logic [PIX_W-1:0]  RST_THICKNESS  = 8'd2;
  localparam logic [PIX_W-1:0]  RST_PAINT_LUMA = 8'd145;
  localparam logic [PIX_W-1:0]  RST_PAINT_CB   = 8'd54;
  localparam logic [PIX_W-1:0]  RST_PAINT_CR   = 8'd34;

  // Samples of one 2x2 cell.
  typedef struct packed {
    logic [PIX_W-1:0] cr;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] luma_br;
    logic [PIX_W-1:0] luma_bl;
    logic [PIX_W-1:0] luma_tr;
    logic [PIX_W-1:0] luma_tl;
  } cell_t;

  typedef struct packed {
    logic [EDGE_W-1:0] box_left;
    logic [EDGE_W-1:0] box_top;
    logic [EDGE_W-1:0] box_right;
    logic [EDGE_W-1:0] box_bottom;
    logic [PIX_W-1:0]  thickness;
    logic [PIX_W-1:0]  paint_luma;
    logic [PIX_W-1:0]  paint_cb;
    logic [PIX_W-1:0]  paint_cr;
  } cfg_t;

  // Edge comparisons for the two columns (or two rows) of a cell.
  // Bit 0 is the even coordinate, bit 1 the odd one.
  typedef struct packed {
    logic [1:0] ge_lo;     // at or past the near edge
    logic [1:0] le_hi;     // at or before the far edge
    logic [1:0] le_lo_in;  // inside the band at the near edge
    logic [1:0] ge_hi_in;  // inside the band at the far edge
    logic [1:0] in_frame;
  } axis_cmp_t;

  typedef struct packed {
    axis_cmp_t x;
    axis_cmp_t y;
    cell_t     pix;
  } cmp_stage_t;

  // hit bit k: k[0] selects the odd column, k[1] the odd row.
  typedef struct packed {
    logic [3:0] hit;
    cell_t      pix;
  } hit_stage_t;

endpackage

>>> design/nbbo_compare.sv
module nbbo_compare #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          in_valid,
  input  logic [nbbo_pkg::CELL_W-1:0]   cell_col,
  input  logic [nbbo_pkg::CELL_W-1:0]   cell_row,
  input  nbbo_pkg::cell_t               pix,
  input  nbbo_pkg::cfg_t                cfg,
  output logic                          out_valid,
  output nbbo_pkg::cmp_stage_t          out_item
);

  localparam int LIM_W = nbbo_pkg::COORD_W + 1;

  nbbo_pkg::axis_cmp_t x_cmp;
  nbbo_pkg::axis_cmp_t y_cmp;

  logic signed [nbbo_pkg::CMP_W-1:0] left_s, right_s, top_s, bottom_s, thick_s;
  logic signed [nbbo_pkg::CMP_W-1:0] left_in, right_in, top_in, bottom_in;
  logic        [nbbo_pkg::COORD_W-1:0] xc [2];
  logic        [nbbo_pkg::COORD_W-1:0] yc [2];
  logic signed [nbbo_pkg::CMP_W-1:0] xs [2];
  logic signed [nbbo_pkg::CMP_W-1:0] ys [2];

  always_comb begin
    left_s   = nbbo_pkg::CMP_W'(signed'(cfg.box_left));
    right_s  = nbbo_pkg::CMP_W'(signed'(cfg.box_right));
    top_s    = nbbo_pkg::CMP_W'(signed'(cfg.box_top));
    bottom_s = nbbo_pkg::CMP_W'(signed'(cfg.box_bottom));
    thick_s  = signed'({{(nbbo_pkg::CMP_W-nbbo_pkg::PIX_W){1'b0}}, cfg.thickness});
    // Inner limits of the bands; with zero thickness the bands are empty.
    left_in   = left_s + thick_s - 16'sd1;
    right_in  = right_s - thick_s + 16'sd1;
    top_in    = top_s + thick_s - 16'sd1;
    bottom_in = bottom_s - thick_s + 16'sd1;
    for (int i = 0; i < 2; i++) begin
      xc[i] = {cell_col, i[0]};
      yc[i] = {cell_row, i[0]};
      xs[i] = signed'({{(nbbo_pkg::CMP_W-nbbo_pkg::COORD_W){1'b0}}, xc[i]});
      ys[i] = signed'({{(nbbo_pkg::CMP_W-nbbo_pkg::COORD_W){1'b0}}, yc[i]});
      x_cmp.ge_lo[i]    = xs[i] >= left_s;
      x_cmp.le_hi[i]    = xs[i] <= right_s;
      x_cmp.le_lo_in[i] = xs[i] <= left_in;
      x_cmp.ge_hi_in[i] = xs[i] >= right_in;
      x_cmp.in_frame[i] = {1'b0, xc[i]} < LIM_W'(MAX_WIDTH);
      y_cmp.ge_lo[i]    = ys[i] >= top_s;
      y_cmp.le_hi[i]    = ys[i] <= bottom_s;
      y_cmp.le_lo_in[i] = ys[i] <= top_in;
      y_cmp.ge_hi_in[i] = ys[i] >= bottom_in;
      y_cmp.in_frame[i] = {1'b0, yc[i]} < LIM_W'(MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.x   <= x_cmp;
      out_item.y   <= y_cmp;
      out_item.pix <= pix;
    end
  end

endmodule

>>> design/nbbo_combine.sv
module nbbo_combine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  in_valid,
  input  nbbo_pkg::cmp_stage_t  in_item,
  output logic                  out_valid,
  output nbbo_pkg::hit_stage_t  out_item
);

  logic [1:0] x_span, x_band, y_span, y_band;
  logic [3:0] hit;

  always_comb begin
    x_span = in_item.x.ge_lo & in_item.x.le_hi;
    y_span = in_item.y.ge_lo & in_item.y.le_hi;
    // Bands are taken literally, even past the opposite edge.
    x_band = (in_item.x.ge_lo & in_item.x.le_lo_in) | (in_item.x.ge_hi_in & in_item.x.le_hi);
    y_band = (in_item.y.ge_lo & in_item.y.le_lo_in) | (in_item.y.ge_hi_in & in_item.y.le_hi);
    for (int k = 0; k < 4; k++) begin
      hit[k] = in_item.x.in_frame[k%2] & in_item.y.in_frame[k/2] &
               ((x_span[k%2] & y_band[k/2]) | (y_span[k/2] & x_band[k%2]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.hit <= hit;
      out_item.pix <= in_item.pix;
    end
  end

endmodule

>>> design/nbbo_paint.sv
module nbbo_paint (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  in_valid,
  input  nbbo_pkg::hit_stage_t  in_item,
  input  nbbo_pkg::cfg_t        cfg,
  output logic                  out_valid,
  output nbbo_pkg::cell_t       out_cell
);

  nbbo_pkg::cell_t painted;
  logic            any_hit;

  always_comb begin
    any_hit = |in_item.hit;
    painted.luma_tl = in_item.hit[0] ? cfg.paint_luma : in_item.pix.luma_tl;
    painted.luma_tr = in_item.hit[1] ? cfg.paint_luma : in_item.pix.luma_tr;
    painted.luma_bl = in_item.hit[2] ? cfg.paint_luma : in_item.pix.luma_bl;
    painted.luma_br = in_item.hit[3] ? cfg.paint_luma : in_item.pix.luma_br;
    painted.cb      = any_hit ? cfg.paint_cb : in_item.pix.cb;
    painted.cr      = any_hit ? cfg.paint_cr : in_item.pix.cr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_cell <= painted;
    end
  end

endmodule

>>> design/nv12_box_border_overlay.sv
// Paints a rectangle outline of programmable thickness and color onto a
// 4:2:0 stream, one 2x2 cell per transaction. Each cell passes through a
// three-stage pipeline (edge compare, border decision, paint); the whole
// pipeline holds while a result waits on m_tready, and otherwise the block
// takes one cell every clock.
// Configuration is written through the cfg port, which is always ready, and
// must only be changed while no cell is in flight.
module nv12_box_border_overlay #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // cell_col, cell_row, luma_top_left, luma_top_right, luma_bottom_left,
  // luma_bottom_right, chroma_cb, chroma_cr, zero fill
  input  logic [nbbo_pkg::IN_W-1:0]    s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // out_luma_top_left, out_luma_top_right, out_luma_bottom_left,
  // out_luma_bottom_right, out_chroma_cb, out_chroma_cr
  output logic [nbbo_pkg::OUT_W-1:0]   m_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [nbbo_pkg::IDX_W-1:0]   cfg_index,
  input  logic [nbbo_pkg::CFG_W-1:0]   cfg_data
);

  nbbo_pkg::cfg_t       cfg;
  nbbo_pkg::cell_t      in_cell;
  nbbo_pkg::cell_t      out_cell;
  nbbo_pkg::cmp_stage_t cmp_item;
  nbbo_pkg::hit_stage_t hit_item;
  logic                 cmp_valid, hit_valid;
  logic                 advance;
  logic [nbbo_pkg::CELL_W-1:0] cell_col, cell_row;

  assign cfg_ready = 1'b1;
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;

  assign cell_col        = s_tdata[10:0];
  assign cell_row        = s_tdata[21:11];
  assign in_cell.luma_tl = s_tdata[29:22];
  assign in_cell.luma_tr = s_tdata[37:30];
  assign in_cell.luma_bl = s_tdata[45:38];
  assign in_cell.luma_br = s_tdata[53:46];
  assign in_cell.cb      = s_tdata[61:54];
  assign in_cell.cr      = s_tdata[69:62];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_left   <= nbbo_pkg::RST_EDGE;
      cfg.box_top    <= nbbo_pkg::RST_EDGE;
      cfg.box_right  <= nbbo_pkg::RST_EDGE;
      cfg.box_bottom <= nbbo_pkg::RST_EDGE;
      cfg.thickness  <= nbbo_pkg::RST_THICKNESS;
      cfg.paint_luma <= nbbo_pkg::RST_PAINT_LUMA;
      cfg.paint_cb   <= nbbo_pkg::RST_PAINT_CB;
      cfg.paint_cr   <= nbbo_pkg::RST_PAINT_CR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nbbo_pkg::REG_BOX_LEFT:   cfg.box_left   <= cfg_data[nbbo_pkg::EDGE_W-1:0];
        nbbo_pkg::REG_BOX_TOP:    cfg.box_top    <= cfg_data[nbbo_pkg::EDGE_W-1:0];
        nbbo_pkg::REG_BOX_RIGHT:  cfg.box_right  <= cfg_data[nbbo_pkg::EDGE_W-1:0];
        nbbo_pkg::REG_BOX_BOTTOM: cfg.box_bottom <= cfg_data[nbbo_pkg::EDGE_W-1:0];
        nbbo_pkg::REG_THICKNESS:  cfg.thickness  <= cfg_data[nbbo_pkg::PIX_W-1:0];
        nbbo_pkg::REG_PAINT_LUMA: cfg.paint_luma <= cfg_data[nbbo_pkg::PIX_W-1:0];
        nbbo_pkg::REG_PAINT_CB:   cfg.paint_cb   <= cfg_data[nbbo_pkg::PIX_W-1:0];
        nbbo_pkg::REG_PAINT_CR:   cfg.paint_cr   <= cfg_data[nbbo_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  nbbo_compare #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_compare (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (s_tvalid),
    .cell_col  (cell_col),
    .cell_row  (cell_row),
    .pix       (in_cell),
    .cfg       (cfg),
    .out_valid (cmp_valid),
    .out_item  (cmp_item)
  );

  nbbo_combine u_combine (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (cmp_valid),
    .in_item   (cmp_item),
    .out_valid (hit_valid),
    .out_item  (hit_item)
  );

  nbbo_paint u_paint (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (hit_valid),
    .in_item   (hit_item),
    .cfg       (cfg),
    .out_valid (m_tvalid),
    .out_cell  (out_cell)
  );

  assign m_tdata = {out_cell.cr, out_cell.cb, out_cell.luma_br, out_cell.luma_bl,
                    out_cell.luma_tr, out_cell.luma_tl};

endmodule

>>> bench/tb_top.sv
module tb_top;

  localparam int FRAME_W       = 4096;
  localparam int FRAME_H       = 4096;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int SESSIONS      = 18;
  localparam int SESSION_CELLS = 100;

  // An index past the last register; a write to it must change nothing.
  localparam logic [nbbo_pkg::IDX_W-1:0] REG_SPARE = 4'd15;

  typedef enum logic [1:0] {OP_CELL, OP_CFG, OP_DRAIN, OP_PACE} op_kind_t;

  typedef struct {
    op_kind_t                    kind;
    logic [nbbo_pkg::IN_W-1:0]   tdata;
    logic [nbbo_pkg::IDX_W-1:0]  idx;
    logic [nbbo_pkg::CFG_W-1:0]  val;
    int                          tx_idle;
    int                          rx_idle;
  } stim_op_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  // cell_col, cell_row, luma_top_left, luma_top_right, luma_bottom_left,
  // luma_bottom_right, chroma_cb, chroma_cr, zero fill
  logic [nbbo_pkg::IN_W-1:0]   s_tdata = '0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  // out_luma_top_left, out_luma_top_right, out_luma_bottom_left,
  // out_luma_bottom_right, out_chroma_cb, out_chroma_cr
  logic [nbbo_pkg::OUT_W-1:0]  m_tdata;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [nbbo_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [nbbo_pkg::CFG_W-1:0]  cfg_data = '0;

  stim_op_t        stim_q[$];
  nbbo_pkg::cell_t painted_q[$];

  // Shadow copy of the overlay registers.
  int         edge_l = 0;
  int         edge_t = 0;
  int         edge_r = 0;
  int         edge_b = 0;
  int         thick  = int'(nbbo_pkg::RST_THICKNESS);
  logic [7:0] ink_y  = nbbo_pkg::RST_PAINT_LUMA;
  logic [7:0] ink_cb = nbbo_pkg::RST_PAINT_CB;
  logic [7:0] ink_cr = nbbo_pkg::RST_PAINT_CR;

  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  nv12_box_border_overlay #(
    .MAX_WIDTH (FRAME_W),
    .MAX_HEIGHT(FRAME_H)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  function automatic bit in_span(int v, int lo, int hi);
    return v >= lo && v <= hi;
  endfunction

  function automatic bit on_border(int x, int y);
    if (x >= FRAME_W || y >= FRAME_H || thick <= 0) return 1'b0;
    if (in_span(x, edge_l, edge_r) &&
        (in_span(y, edge_t, edge_t + thick - 1) || in_span(y, edge_b - thick + 1, edge_b)))
      return 1'b1;
    if (in_span(y, edge_t, edge_b) &&
        (in_span(x, edge_l, edge_l + thick - 1) || in_span(x, edge_r - thick + 1, edge_r)))
      return 1'b1;
    return 1'b0;
  endfunction

  function automatic nbbo_pkg::cell_t paint_cell(logic [nbbo_pkg::IN_W-1:0] d);
    nbbo_pkg::cell_t res;
    int    x0;
    int    y0;
    bit    any;
    res = d[2*nbbo_pkg::CELL_W +: $bits(nbbo_pkg::cell_t)];
    x0  = 2 * int'(d[nbbo_pkg::CELL_W-1:0]);
    y0  = 2 * int'(d[2*nbbo_pkg::CELL_W-1:nbbo_pkg::CELL_W]);
    any = 1'b0;
    if (on_border(x0, y0)) begin
      res.luma_tl = ink_y;
      any = 1'b1;
    end
    if (on_border(x0 + 1, y0)) begin
      res.luma_tr = ink_y;
      any = 1'b1;
    end
    if (on_border(x0, y0 + 1)) begin
      res.luma_bl = ink_y;
      any = 1'b1;
    end
    if (on_border(x0 + 1, y0 + 1)) begin
      res.luma_br = ink_y;
      any = 1'b1;
    end
    if (any) begin
      res.cb = ink_cb;
      res.cr = ink_cr;
    end
    return res;
  endfunction

  function automatic void apply_cfg(logic [nbbo_pkg::IDX_W-1:0] idx,
                                    logic [nbbo_pkg::CFG_W-1:0] val);
    case (idx)
      nbbo_pkg::REG_BOX_LEFT:   edge_l = int'($signed(val[nbbo_pkg::EDGE_W-1:0]));
      nbbo_pkg::REG_BOX_TOP:    edge_t = int'($signed(val[nbbo_pkg::EDGE_W-1:0]));
      nbbo_pkg::REG_BOX_RIGHT:  edge_r = int'($signed(val[nbbo_pkg::EDGE_W-1:0]));
      nbbo_pkg::REG_BOX_BOTTOM: edge_b = int'($signed(val[nbbo_pkg::EDGE_W-1:0]));
      nbbo_pkg::REG_THICKNESS:  thick  = int'(val[nbbo_pkg::PIX_W-1:0]);
      nbbo_pkg::REG_PAINT_LUMA: ink_y  = val[nbbo_pkg::PIX_W-1:0];
      nbbo_pkg::REG_PAINT_CB:   ink_cb = val[nbbo_pkg::PIX_W-1:0];
      nbbo_pkg::REG_PAINT_CR:   ink_cr = val[nbbo_pkg::PIX_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic push_cell(int col, int row, nbbo_pkg::cell_t pix);
    stim_op_t op;
    op.kind  = OP_CELL;
    op.tdata = {(nbbo_pkg::IN_W - 2*nbbo_pkg::CELL_W - $bits(nbbo_pkg::cell_t))'(0), pix,
                nbbo_pkg::CELL_W'(row), nbbo_pkg::CELL_W'(col)};
    stim_q.push_back(op);
  endtask

  task automatic push_cfg(logic [nbbo_pkg::IDX_W-1:0] idx, int val);
    stim_op_t op;
    op.kind = OP_CFG;
    op.idx  = idx;
    op.val  = nbbo_pkg::CFG_W'(val);
    stim_q.push_back(op);
  endtask

  task automatic push_drain();
    stim_op_t op;
    op.kind = OP_DRAIN;
    stim_q.push_back(op);
  endtask

  task automatic push_pace(int tx, int rx);
    stim_op_t op;
    op.kind    = OP_PACE;
    op.tx_idle = tx;
    op.rx_idle = rx;
    stim_q.push_back(op);
  endtask

  // Registers may only change with the pipeline empty, so each group of
  // writes waits for all outstanding cells first.
  task automatic set_box(int l, int t, int r, int b, int th);
    push_drain();
    push_cfg(nbbo_pkg::REG_BOX_LEFT, l);
    push_cfg(nbbo_pkg::REG_BOX_TOP, t);
    push_cfg(nbbo_pkg::REG_BOX_RIGHT, r);
    push_cfg(nbbo_pkg::REG_BOX_BOTTOM, b);
    push_cfg(nbbo_pkg::REG_THICKNESS, th);
  endtask

  task automatic set_paint(int y, int cb, int cr);
    push_drain();
    push_cfg(nbbo_pkg::REG_PAINT_LUMA, y);
    push_cfg(nbbo_pkg::REG_PAINT_CB, cb);
    push_cfg(nbbo_pkg::REG_PAINT_CR, cr);
  endtask

  function automatic nbbo_pkg::cell_t random_pix();
    nbbo_pkg::cell_t pix;
    pix = {$urandom(), 16'($urandom())};
    return pix;
  endfunction

  // Pixel coordinate biased toward the outer and inner sides of both edges.
  function automatic int pick_coord(int a, int c, int th);
    int lo;
    int hi;
    int v;
    lo = (a < c) ? a : c;
    hi = (a < c) ? c : a;
    case ($urandom_range(4))
      0:       v = a + int'($urandom_range(8)) - 4;
      1:       v = c + int'($urandom_range(8)) - 4;
      2:       v = a + th + int'($urandom_range(8)) - 4;
      3:       v = c - th + int'($urandom_range(8)) - 4;
      default: v = lo + int'($urandom_range(hi - lo));
    endcase
    if ($urandom_range(7) == 0) v = int'($urandom_range(FRAME_W - 1));
    if (v < 0) v = 0;
    if (v > FRAME_W - 1) v = FRAME_W - 1;
    return v;
  endfunction

  task automatic random_session(int style, int cells);
    int l;
    int t;
    int r;
    int b;
    int th;
    int tmp;
    l  = int'($urandom_range(300)) - 30;
    r  = l + int'($urandom_range(240));
    t  = int'($urandom_range(300)) - 30;
    b  = t + int'($urandom_range(240));
    th = int'($urandom_range(6, 1));
    case (style)
      1: th = 0;
      2: begin
        tmp = l;
        l   = r + 4;
        r   = tmp;
        if ($urandom_range(1) == 1) begin
          tmp = t;
          t   = b + 2;
          b   = tmp;
        end
      end
      3: th = int'($urandom_range(255, 100));
      4: begin
        l  = -8192;
        b  = 8191;
        th = int'($urandom_range(40, 1));
      end
      5: begin
        // Box hanging off the right and bottom of the frame.
        l  = int'($urandom_range(4095, 3900));
        r  = l + int'($urandom_range(300));
        t  = int'($urandom_range(4095, 3900));
        b  = t + int'($urandom_range(300));
        th = int'($urandom_range(12, 1));
      end
      default: ;
    endcase
    set_box(l, t, r, b, th);
    set_paint(int'($urandom_range(255)), int'($urandom_range(255)), int'($urandom_range(255)));
    repeat (cells) begin
      push_cell(pick_coord(l, r, th) / 2, pick_coord(t, b, th) / 2, random_pix());
    end
  endtask

  always @(posedge clk) begin : driver
    logic hold_cell;
    logic hold_cfg;
    if (rst) begin
      s_tvalid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) painted_q.push_back(paint_cell(s_tdata));
      hold_cell = s_tvalid && !s_tready;
      hold_cfg  = cfg_valid && !cfg_ready;
      if (!hold_cell && !hold_cfg && stim_q.size() > 0) begin
        case (stim_q[0].kind)
          OP_CELL: begin
            if ($urandom_range(99) >= tx_idle_pct) begin
              s_tdata   <= stim_q[0].tdata;
              hold_cell = 1'b1;
              void'(stim_q.pop_front());
            end
          end
          OP_CFG: begin
            cfg_index <= stim_q[0].idx;
            cfg_data  <= stim_q[0].val;
            hold_cfg  = 1'b1;
            void'(stim_q.pop_front());
          end
          OP_DRAIN: begin
            if (painted_q.size() == 0) void'(stim_q.pop_front());
          end
          OP_PACE: begin
            tx_idle_pct = stim_q[0].tx_idle;
            rx_idle_pct = stim_q[0].rx_idle;
            void'(stim_q.pop_front());
          end
          default: ;
        endcase
      end
      s_tvalid  <= hold_cell;
      cfg_valid <= hold_cfg;
    end
  end

  always @(posedge clk) begin : monitor
    nbbo_pkg::cell_t got;
    nbbo_pkg::cell_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (painted_q.size() == 0) begin
          $error("result transaction with no cell pending: %h", m_tdata);
          mismatches++;
        end else begin
          want = painted_q.pop_front();
          check_field("out_luma_top_left", want.luma_tl, got.luma_tl);
          check_field("out_luma_top_right", want.luma_tr, got.luma_tr);
          check_field("out_luma_bottom_left", want.luma_bl, got.luma_bl);
          check_field("out_luma_bottom_right", want.luma_br, got.luma_br);
          check_field("out_chroma_cb", want.cb, got.cb);
          check_field("out_chroma_cr", want.cr, got.cr);
        end
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    push_pace(27, 60);

    // Reset settings: a one-pixel box at the origin, two layers thick.
    push_cell(0, 0, '0);
    push_cell(2047, 2047, '1);
    push_cell(0, 1, random_pix());

    set_paint(0, 255, 0);
    set_box(3, 5, 20, 17, 2);
    push_cell(1, 2, random_pix());
    push_cell(0, 2, random_pix());
    push_cell(5, 3, random_pix());
    push_cell(5, 5, random_pix());
    push_cell(10, 8, random_pix());
    push_cell(1, 9, random_pix());
    push_cell(5, 8, random_pix());

    // Zero thickness paints nothing.
    set_box(3, 5, 20, 17, 0);
    push_cell(1, 2, random_pix());

    // Inverted columns: no row segment, and the column bands run past each other.
    set_box(20, 5, 3, 17, 4);
    set_paint(255, 0, 255);
    push_cell(10, 4, random_pix());
    push_cell(1, 4, random_pix());
    push_cell(5, 2, random_pix());
    push_drain();
    push_cfg(REG_SPARE, 16'h1234);
    push_cell(10, 4, random_pix());

    // Widest box: every band lies outside the frame.
    set_box(-8192, -8192, 8191, 8191, 255);
    push_cell(0, 0, random_pix());
    push_cell(2047, 2047, random_pix());

    set_box(-8192, 0, 100, 8191, 255);
    push_cell(30, 30, random_pix());
    push_cell(60, 60, random_pix());

    set_box(4000, 4000, 8191, 8191, 255);
    push_cell(2047, 2047, random_pix());

    for (int s = 0; s < SESSIONS; s++) begin
      if (s == SESSIONS / 3) push_pace(60, 27);
      if (s == 2 * SESSIONS / 3) push_pace(0, 0);
      random_session(s % 6, SESSION_CELLS);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (stim_q.size() != 0 || s_tvalid || cfg_valid || painted_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> nv12_box_border_overlay.f
design/nbbo_pkg.sv
design/nbbo_compare.sv
design/nbbo_combine.sv
design/nbbo_paint.sv
design/nv12_box_border_overlay.sv
bench/tb_top.sv
